>>> rtl/core/quoted_list_literal_parser_macros.svh
// Assertion macros used by the quoted list literal parser checker.
`ifndef QUOTED_LIST_LITERAL_PARSER_MACROS_SVH
`define QUOTED_LIST_LITERAL_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define QLP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qlp check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define QLP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qlp check failed");

`endif

>>> rtl/core/qlp_pkg.sv
// Shared types and constants of the quoted list literal parser.
package qlp_pkg;

   typedef logic [7:0] chr_type;
   typedef logic [1:0] status_type;

   // Character codes of the grammar
   localparam chr_type CHR_SPACE  = 8'h20;
   localparam chr_type CHR_TAB    = 8'h09;
   localparam chr_type CHR_SQUOTE = 8'h27;
   localparam chr_type CHR_DQUOTE = 8'h22;
   localparam chr_type CHR_LBRACE = 8'h7B;
   localparam chr_type CHR_RBRACE = 8'h7D;
   localparam chr_type CHR_COMMA  = 8'h2C;

   // Final status codes
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_MALFORMED = 2'd1;
   localparam status_type STATUS_UNEXP_END = 2'd2;

   // Default depth of the queue between front and back
   localparam int QLP_QUEUE_DEPTH = 2;

   // Character class found by the front
   typedef enum logic [2:0] {
      CLS_BLANK  = 3'd0,
      CLS_LBRACE = 3'd1,
      CLS_RBRACE = 3'd2,
      CLS_COMMA  = 3'd3,
      CLS_SQUOTE = 3'd4,
      CLS_DQUOTE = 3'd5,
      CLS_OTHER  = 3'd6
   } cls_type;

   // Parser states, one-hot
   typedef enum logic [7:0] {
      ST_OPEN   = 8'b0000_0001,
      ST_FIRST  = 8'b0000_0010,
      ST_IN_SQ  = 8'b0000_0100,
      ST_IN_DQ  = 8'b0000_1000,
      ST_AFT_SQ = 8'b0001_0000,
      ST_AFT_DQ = 8'b0010_0000,
      ST_COMMA  = 8'b0100_0000,
      ST_TAIL   = 8'b1000_0000
   } state_type;

   // One classified character in flight
   typedef struct packed {
      chr_type chr;
      logic    is_last;
      cls_type cls;
   } item_type;

   // Front to queue
   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   // Queue head to back
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   function automatic cls_type classify(chr_type c);
      cls_type r;
      if (c == CHR_SPACE || c == CHR_TAB) r = CLS_BLANK;
      else if (c == CHR_LBRACE) r = CLS_LBRACE;
      else if (c == CHR_RBRACE) r = CLS_RBRACE;
      else if (c == CHR_COMMA) r = CLS_COMMA;
      else if (c == CHR_SQUOTE) r = CLS_SQUOTE;
      else if (c == CHR_DQUOTE) r = CLS_DQUOTE;
      else r = CLS_OTHER;
      return r;
   endfunction

endpackage

>>> rtl/core/qlp_ifs.sv
// Valid/ready channel interfaces of the quoted list literal parser.
interface qlp_req_if;
   import qlp_pkg::*;
   logic    valid;
   logic    ready;
   chr_type chr;
   logic    is_last;

   modport source (output valid, output chr, output is_last, input ready);
   modport sink   (input valid, input chr, input is_last, output ready);
endinterface

interface qlp_rsp_if;
   import qlp_pkg::*;
   logic       valid;
   logic       ready;
   chr_type    out_char;
   logic       char_valid;
   logic       element_end;
   logic       error_seen;
   logic       list_done;
   status_type status;

   modport source (output valid, output out_char, output char_valid, output element_end,
                   output error_seen, output list_done, output status, input ready);
   modport sink   (input valid, input out_char, input char_valid, input element_end,
                   input error_seen, input list_done, input status, output ready);
endinterface

>>> rtl/core/quoted_list_literal_parser.sv
// Quoted list literal parser, top level.
//
//   Channel   Dir  Payload                                         Transfer
//   req_ch    in   chr[7:0], is_last                                valid && ready
//   rsp_ch    out  out_char[7:0], char_valid, element_end,          valid && ready
//                  error_seen, list_done, status[1:0]
//
// One character per cycle sustained while rsp_ch.ready stays high. An input
// character is written into the queue, then loads the result register of the
// back end, which drives rsp_ch.valid and the result payload.
// Front and back are split by a QUEUE_DEPTH entry queue, so a stall on rsp_ch
// reaches req_ch.ready only once the queue and result register are full.
// Synchronous active-high reset empties the queue and rearms the parser.
module quoted_list_literal_parser #(
   parameter int QUEUE_DEPTH = qlp_pkg::QLP_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   qlp_req_if.sink   req_ch,
   qlp_rsp_if.source rsp_ch
);
   import qlp_pkg::*;

   push_type push;
   head_type head;
   logic     q_full;
   logic     pop;

   qlp_front u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .push   (push)
   );

   qlp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   qlp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

>>> rtl/core/qlp_front.sv
// Front end: takes input transfers and classifies each character.
module qlp_front (
   qlp_req_if.sink            req_ch,
   input  logic               q_full,
   output qlp_pkg::push_type  push
);
   import qlp_pkg::*;

   // Accept whenever the queue has room
   assign req_ch.ready      = !q_full;
   assign push.valid        = req_ch.valid && !q_full;
   assign push.item.chr     = req_ch.chr;
   assign push.item.is_last = req_ch.is_last;
   assign push.item.cls     = classify(req_ch.chr);

endmodule

>>> rtl/core/qlp_queue.sv
// Short queue of classified characters between front and back.
module qlp_queue #(
   parameter int DEPTH = qlp_pkg::QLP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  qlp_pkg::push_type push,
   input  logic              pop,
   output logic              full,
   output qlp_pkg::head_type head
);
   import qlp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   item_type         entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full       = (cnt_ff == CNT_FULL);
   assign head.valid = (cnt_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

>>> rtl/core/qlp_back.sv
// Back end: grammar state machine and registered result stage.
module qlp_back (
   input  logic              clock,
   input  logic              reset,
   input  qlp_pkg::head_type head,
   output logic              pop,
   qlp_rsp_if.source         rsp_ch
);
   import qlp_pkg::*;

   state_type  state_ff, state_in;
   logic       err_ff, err_in;
   logic       rsp_valid_ff, rsp_valid_in;
   chr_type    out_char_ff;
   logic       char_valid_ff, element_end_ff, error_seen_ff, list_done_ff;
   status_type status_ff;

   state_type  nxt_st, upd_st;
   logic       bad, upd_err, cv, ee;
   chr_type    och;
   status_type sts;
   cls_type    cls;

   assign cls = head.item.cls;
   // Result register is free or being drained
   assign pop = head.valid && (!rsp_valid_ff || rsp_ch.ready);

   // Grammar step; nothing moves once an error is latched
   always_comb begin
      nxt_st = state_ff;
      bad    = 1'b0;
      och    = '0;
      cv     = 1'b0;
      ee     = 1'b0;
      if (!err_ff) begin
         case (state_ff)
            ST_OPEN: begin
               if (cls == CLS_LBRACE) nxt_st = ST_FIRST;
               else if (cls != CLS_BLANK) bad = 1'b1;
            end
            ST_FIRST, ST_COMMA: begin
               if (cls == CLS_SQUOTE) nxt_st = ST_IN_SQ;
               else if (cls == CLS_DQUOTE) nxt_st = ST_IN_DQ;
               else if (cls != CLS_BLANK) bad = 1'b1;
            end
            ST_IN_SQ: begin
               if (cls == CLS_SQUOTE) begin
                  ee     = 1'b1;
                  nxt_st = ST_AFT_SQ;
               end else begin
                  och = head.item.chr;
                  cv  = 1'b1;
               end
            end
            ST_IN_DQ: begin
               if (cls == CLS_DQUOTE) begin
                  ee     = 1'b1;
                  nxt_st = ST_AFT_DQ;
               end else begin
                  och = head.item.chr;
                  cv  = 1'b1;
               end
            end
            ST_AFT_SQ, ST_AFT_DQ: begin
               if (cls == CLS_COMMA) nxt_st = ST_COMMA;
               else if (cls == CLS_RBRACE) nxt_st = ST_TAIL;
               else if (cls != CLS_BLANK) bad = 1'b1;
            end
            ST_TAIL: begin
               if (cls != CLS_BLANK) bad = 1'b1;
            end
            default: begin
               bad = 1'b1;
            end
         endcase
      end
      upd_err = err_ff | bad;
      upd_st  = bad ? state_ff : nxt_st;
      if (!head.item.is_last) sts = STATUS_OK;
      else if (upd_err) sts = STATUS_MALFORMED;
      else if (upd_st == ST_TAIL) sts = STATUS_OK;
      else sts = STATUS_UNEXP_END;
   end

   // Next state; the last character rearms for a new string
   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      if (pop) begin
         if (head.item.is_last) begin
            state_in = ST_OPEN;
            err_in   = 1'b0;
         end else begin
            state_in = upd_st;
            err_in   = upd_err;
         end
      end
      if (pop) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_OPEN;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         out_char_ff    <= och;
         char_valid_ff  <= cv;
         element_end_ff <= ee;
         error_seen_ff  <= upd_err;
         list_done_ff   <= head.item.is_last;
         status_ff      <= sts;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_char    = out_char_ff;
   assign rsp_ch.char_valid  = char_valid_ff;
   assign rsp_ch.element_end = element_end_ff;
   assign rsp_ch.error_seen  = error_seen_ff;
   assign rsp_ch.list_done   = list_done_ff;
   assign rsp_ch.status      = status_ff;

endmodule

>>> rtl/core/qlp_checker.sv
// Port-level checks of the quoted list literal parser, bound to the top level.
`include "quoted_list_literal_parser_macros.svh"

module qlp_checker (
   input logic       clock,
   input logic       reset,
   qlp_req_if.sink   req_ch,
   qlp_rsp_if.source rsp_ch
);
   import qlp_pkg::*;

   logic rsp_xfer;
   assign rsp_xfer = rsp_ch.valid && rsp_ch.ready;

   // A stalled result holds
   `QLP_ASSERT_NEXT(a_rsp_hold, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid && $stable(rsp_ch.out_char) && $stable(rsp_ch.status) && $stable(rsp_ch.list_done))

   // Streamed character and element end never coincide
   `QLP_ASSERT_NOW(a_char_xor_end, rsp_ch.valid, !(rsp_ch.char_valid && rsp_ch.element_end))

   // No streaming once an error is latched
   `QLP_ASSERT_NOW(a_err_quiet, rsp_ch.valid && rsp_ch.error_seen, !rsp_ch.char_valid && !rsp_ch.element_end)

   // Status is zero except on the last character
   `QLP_ASSERT_NOW(a_status_idle, rsp_ch.valid && !rsp_ch.list_done, rsp_ch.status == STATUS_OK)

   // Final status is malformed exactly when an error was seen
   `QLP_ASSERT_NOW(a_status_err, rsp_xfer && rsp_ch.list_done, (rsp_ch.status == STATUS_MALFORMED) == rsp_ch.error_seen)

endmodule

bind quoted_list_literal_parser qlp_checker u_qlp_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
